// ===== rtl/mcpdtc_pkg.sv =====
`timescale 1ns / 1ps
package mcpdtc_pkg;

  localparam int MAX_CH = 4;

  localparam int MEAS_W = 20;
  localparam int ERR_W  = 21;
  localparam int DIFF_W = 22;
  localparam int GAIN_W = 24;
  localparam int LIM_W  = 23;
  localparam int CMD_W  = 24;
  localparam int PKP_W  = GAIN_W + ERR_W;
  localparam int PKD_W  = GAIN_W + DIFF_W;
  localparam int SUM_W  = 48;
  localparam int FRAC_W = 16;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic signed [GAIN_W-1:0] KP_RST  = 24'sd573440;
  localparam logic signed [GAIN_W-1:0] KD_RST  = 24'sd0;
  localparam logic        [LIM_W-1:0]  LIM_RST = 23'd300000;
  localparam logic signed [MEAS_W-1:0] TGT_RST = 20'sd1600;

  typedef logic signed [MEAS_W-1:0] meas_t;
  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic        [LIM_W-1:0]  lim_t;
  typedef logic signed [CMD_W-1:0]  cmd_t;

  typedef struct packed {
    err_t  [MAX_CH-1:0] err;
    diff_t [MAX_CH-1:0] diff;
  } frame_t;

  typedef enum logic [2:0] {
    REG_KP   = 3'd0,
    REG_KD   = 3'd1,
    REG_MAX  = 3'd2,
    REG_TGT0 = 3'd3,
    REG_TGT1 = 3'd4,
    REG_TGT2 = 3'd5,
    REG_TGT3 = 3'd6
  } reg_idx_t;

endpackage

// ===== rtl/mcpdtc_front.sv =====
`timescale 1ns / 1ps
module mcpdtc_front #(
  parameter int CHANNELS = 4
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  mcpdtc_pkg::meas_t [mcpdtc_pkg::MAX_CH-1:0] meas,
  input  mcpdtc_pkg::meas_t [mcpdtc_pkg::MAX_CH-1:0] tgt,
  output logic                                       push_valid,
  input  logic                                       push_ready,
  output mcpdtc_pkg::frame_t                         push_frame
);
  import mcpdtc_pkg::*;

  logic  accept;
  err_t  err_a  [MAX_CH];
  diff_t diff_a [MAX_CH];

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  for (genvar c = 0; c < MAX_CH; c++) begin : g_lane
    if (c < CHANNELS) begin : g_act
      err_t prev_r;

      assign err_a[c]  = ERR_W'($signed(tgt[c])) - ERR_W'($signed(meas[c]));
      assign diff_a[c] = DIFF_W'(err_a[c]) - DIFF_W'(prev_r);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          prev_r <= '0;
        end else if (accept) begin
          prev_r <= err_a[c];
        end
      end
    end else begin : g_idle
      // An unused lane carries zeros, so the back end produces a zero command.
      assign err_a[c]  = '0;
      assign diff_a[c] = '0;
    end
  end

  always_comb begin
    push_frame = '0;
    for (int c = 0; c < MAX_CH; c++) begin
      push_frame.err[c]  = err_a[c];
      push_frame.diff[c] = diff_a[c];
    end
  end

endmodule

// ===== rtl/mcpdtc_queue.sv =====
`timescale 1ns / 1ps
module mcpdtc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  mcpdtc_pkg::frame_t push_frame,
  output logic               pop_valid,
  input  logic               pop_ready,
  output mcpdtc_pkg::frame_t pop_frame
);
  import mcpdtc_pkg::*;

  frame_t           mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW-1:0]   rd_ptr_nxt;
  logic [QCW-1:0]   count_r;
  logic [QCW-1:0]   count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != QCW'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_frame  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : QAW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : QAW'(rd_ptr_r + 1'b1);
    end
    count_nxt = QCW'(count_r + QCW'(do_push) - QCW'(do_pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("queue occupancy beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == QCW'($past(count_r) + 1'b1))
    else $error("queue occupancy lost a pushed beat");
`endif

endmodule

// ===== rtl/mcpdtc_back.sv =====
`timescale 1ns / 1ps
module mcpdtc_back (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      pop_valid,
  output logic                                      pop_ready,
  input  mcpdtc_pkg::frame_t                        frame,
  input  mcpdtc_pkg::gain_t                         kp,
  input  mcpdtc_pkg::gain_t                         kd,
  input  mcpdtc_pkg::lim_t                          lim,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output mcpdtc_pkg::cmd_t [mcpdtc_pkg::MAX_CH-1:0] out_cmd
);
  import mcpdtc_pkg::*;

  logic                    s1_v_r;
  logic                    s2_v_r;
  logic                    out_v_r;
  logic                    s1_rdy;
  logic                    s2_rdy;
  logic                    s3_rdy;

  logic signed [PKP_W-1:0] pkp_r   [MAX_CH];
  logic signed [PKP_W-1:0] pkp_nxt [MAX_CH];
  logic signed [PKD_W-1:0] pkd_r   [MAX_CH];
  logic signed [PKD_W-1:0] pkd_nxt [MAX_CH];
  logic signed [SUM_W-1:0] sum_r   [MAX_CH];
  logic signed [SUM_W-1:0] sum_nxt [MAX_CH];
  cmd_t                    cmd_r   [MAX_CH];
  cmd_t                    cmd_nxt [MAX_CH];

  logic [SUM_W-1:0]        mag     [MAX_CH];
  logic [SUM_W-FRAC_W-1:0] quo     [MAX_CH];
  lim_t                    clip    [MAX_CH];
  logic                    within_lim;
  logic [CMD_W-1:0]        abs0;

  assign s3_rdy    = !out_v_r || out_ready;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign pop_ready = s1_rdy;
  assign out_valid = out_v_r;

  always_comb begin
    for (int c = 0; c < MAX_CH; c++) begin
      pkp_nxt[c] = kp * $signed(frame.err[c]);
      pkd_nxt[c] = kd * $signed(frame.diff[c]);
      sum_nxt[c] = -(SUM_W'(pkp_r[c]) + SUM_W'(pkd_r[c]));
      // Truncation toward zero: shift the magnitude, then restore the sign.
      mag[c]  = sum_r[c][SUM_W-1] ? SUM_W'(-sum_r[c]) : SUM_W'(sum_r[c]);
      quo[c]  = mag[c][SUM_W-1:FRAC_W];
      clip[c] = (quo[c] > (SUM_W-FRAC_W)'(lim)) ? lim : quo[c][LIM_W-1:0];
      cmd_nxt[c] = sum_r[c][SUM_W-1] ? -CMD_W'(clip[c]) : CMD_W'(clip[c]);
      out_cmd[c] = cmd_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= pop_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < MAX_CH; c++) begin
      if (s1_rdy && pop_valid) begin
        pkp_r[c] <= pkp_nxt[c];
        pkd_r[c] <= pkd_nxt[c];
      end
      if (s2_rdy && s1_v_r) begin
        sum_r[c] <= sum_nxt[c];
      end
      if (s3_rdy && s2_v_r) begin
        cmd_r[c] <= cmd_nxt[c];
      end
    end
  end

  always_comb begin
    abs0       = cmd_r[0][CMD_W-1] ? CMD_W'(-cmd_r[0]) : CMD_W'(cmd_r[0]);
    within_lim = (abs0 <= CMD_W'(lim));
  end

`ifndef SYNTHESIS
  a_cmd_limited: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> within_lim)
    else $error("command magnitude exceeds the limit");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s3_rdy) |=> (s2_v_r && $stable(sum_r[0])))
    else $error("stalled sum stage lost its beat");
`endif

endmodule

// ===== rtl/multi_channel_pd_tension_control_top.sv =====
`timescale 1ns / 1ps
// Four-lane PD tension controller. Each input beat carries one Q16.4 tension sample per
// channel; the block forms error = target - sample, computes
// -(kp*error + kd*(error - previous error)) with Q12.12 gains, drops 16 fraction bits
// toward zero and clamps the magnitude to max_command. One result beat is produced per
// input beat, in order. A new frame is accepted every clock cycle unless out_ready
// back-pressure fills the queue; the error subtract and previous-error update sit in
// the front end. A frame passes the two-entry decoupling queue, the multiplier stage,
// the sum stage and the output register, fed by the clamp. Configuration registers
// are to be written through cfg_we/cfg_index/cfg_wdata only while the block is idle;
// the block itself does not enforce this. Unknown indices are ignored.
module multi_channel_pd_tension_control_top #(
  parameter int CHANNELS = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [19:0]        in_measurement_0,
  input  logic signed [19:0]        in_measurement_1,
  input  logic signed [19:0]        in_measurement_2,
  input  logic signed [19:0]        in_measurement_3,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [23:0]        out_command_0,
  output logic signed [23:0]        out_command_1,
  output logic signed [23:0]        out_command_2,
  output logic signed [23:0]        out_command_3,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [23:0]               cfg_wdata
);
  import mcpdtc_pkg::*;

  gain_t               kp_r;
  gain_t               kd_r;
  lim_t                lim_r;
  meas_t [MAX_CH-1:0]  tgt_r;
  meas_t [MAX_CH-1:0]  meas;
  cmd_t  [MAX_CH-1:0]  cmd;

  logic                q_push_valid;
  logic                q_push_ready;
  frame_t              q_push_frame;
  logic                q_pop_valid;
  logic                q_pop_ready;
  frame_t              q_pop_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= KP_RST;
      kd_r  <= KD_RST;
      lim_r <= LIM_RST;
      tgt_r <= {MAX_CH{TGT_RST}};
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KP:   kp_r     <= cfg_wdata[GAIN_W-1:0];
        REG_KD:   kd_r     <= cfg_wdata[GAIN_W-1:0];
        REG_MAX:  lim_r    <= cfg_wdata[LIM_W-1:0];
        REG_TGT0: tgt_r[0] <= cfg_wdata[MEAS_W-1:0];
        REG_TGT1: tgt_r[1] <= cfg_wdata[MEAS_W-1:0];
        REG_TGT2: tgt_r[2] <= cfg_wdata[MEAS_W-1:0];
        REG_TGT3: tgt_r[3] <= cfg_wdata[MEAS_W-1:0];
        default: ;
      endcase
    end
  end

  assign meas[0] = in_measurement_0;
  assign meas[1] = in_measurement_1;
  assign meas[2] = in_measurement_2;
  assign meas[3] = in_measurement_3;

  mcpdtc_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .meas       (meas),
    .tgt        (tgt_r),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_frame (q_push_frame)
  );

  mcpdtc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_frame (q_push_frame),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_frame  (q_pop_frame)
  );

  mcpdtc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .frame     (q_pop_frame),
    .kp        (kp_r),
    .kd        (kd_r),
    .lim       (lim_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_cmd   (cmd)
  );

  assign out_command_0 = cmd[0];
  assign out_command_1 = cmd[1];
  assign out_command_2 = cmd[2];
  assign out_command_3 = cmd[3];

endmodule
